// ----- sv/dcc_pkg.sv -----
// Package for the dispenser countdown controller: types, constants and digit helpers.
package dcc_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned ADC_W   = 10;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] PRESS_TICKS_RST = 16'd3000;
  localparam logic [TICK_W-1:0] SIGN_TICKS_RST  = 16'd10000;
  localparam logic [TICK_W-1:0] STEP_TICKS_RST  = 16'd1000;

  // Sample thresholds where 2*adc/1020 steps up.
  localparam logic [ADC_W-1:0] ADC_STEP1 = 10'd510;
  localparam logic [ADC_W-1:0] ADC_STEP2 = 10'd1020;

  localparam logic [COUNT_W-1:0] LOAD_BASE = 7'd50;
  localparam logic [COUNT_W-1:0] LOAD_MID  = 7'd60;
  localparam logic [COUNT_W-1:0] LOAD_TOP  = 7'd70;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_TICKS = 2'd0,
    REG_SIGN_TICKS  = 2'd1,
    REG_STEP_TICKS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SIGN = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [3:0] second_ones;
    logic [2:0] second_tens;
    logic [3:0] minute_ones;
    logic [3:0] minute_tens;
    logic       show_on_sign;
    logic       display_enabled;
    logic       motor_on;
  } result_t;

  // Count to load from the sample: 10*(5 + 2*adc/1020).
  function automatic logic [COUNT_W-1:0] load_count(input logic [ADC_W-1:0] adc);
    logic [COUNT_W-1:0] cnt;
    if (adc >= ADC_STEP2) begin
      cnt = LOAD_TOP;
    end else if (adc >= ADC_STEP1) begin
      cnt = LOAD_MID;
    end else begin
      cnt = LOAD_BASE;
    end
    return cnt;
  endfunction

  // Whole seconds of a tenths count: multiply by reciprocal, exact for any 7-bit count.
  function automatic logic [3:0] tenths_to_sec(input logic [COUNT_W-1:0] cnt);
    logic [14:0] prod;
    prod = 15'(cnt) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

// ----- sv/dispenser_countdown_controller_core.sv -----
// Top level of the dispenser countdown controller: press detector, phase timer, digit output.
//
// Usage:
//   in_*  : one item per base tick, tdata = {adc_value, button_low} from bit 0 up.
//   out_* : one result item per input item with motor, display and sign flags and the
//           minute and second digits of the remaining count (tenths of a second).
//   cfg_* : write press_ticks, sign_ticks, step_ticks by index; write only while idle.
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per clock. The state update and the digit logic sit between the
//   state registers and the output register, so the next item is taken in the cycle
//   the previous result leaves, or while the output register is empty.
// Stall: while out_tready is low and a result waits, in_tready drops and the result holds.
// Reset (rst_n low, synchronous): phase idle, press detector armed, counters zero,
//   registers back to 3000 / 10000 / 1000, output register empty.
// The count never exceeds 70 tenths, so the minute digits and the seconds tens digit
//   stay zero in practice; the seconds tens digit is still derived from the count.
module dispenser_countdown_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dcc_pkg::IN_W-1:0]        in_tdata,   // [0] button_low, [10:1] adc_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] motor_on, [1] display_enabled, [2] show_on_sign, [6:3] minute_tens,
  // [10:7] minute_ones, [13:11] second_tens, [17:14] second_ones
  output logic [dcc_pkg::OUT_W-1:0]       out_tdata,
  input  logic                            cfg_we,
  input  logic [dcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcc_pkg::TICK_W-1:0]      cfg_wdata
);
  import dcc_pkg::*;

  // Configuration registers
  logic [TICK_W-1:0] press_ticks_r;
  logic [TICK_W-1:0] sign_ticks_r;
  logic [TICK_W-1:0] step_ticks_r;

  // Controller state
  phase_t             phase_r, phase_nxt;
  logic [TICK_W-1:0]  press_count_r, press_count_nxt;
  logic               press_armed_r, press_armed_nxt;
  logic [TICK_W-1:0]  phase_ticks_r, phase_ticks_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;

  // Output register
  logic               out_tvalid_r;
  result_t            result_r, result_nxt;

  logic               in_accept;
  logic               out_accept;
  logic               button_low;
  logic [ADC_W-1:0]   adc_value;
  logic               toggled;
  logic [TICK_W-1:0]  ticks_inc;
  logic [COUNT_W-1:0] rem_dec;
  logic [COUNT_W-1:0] cnt;
  logic [3:0]         secs;

  assign button_low = in_tdata[0];
  assign adc_value  = in_tdata[ADC_W:1];

  // Take a new item whenever the output register is free or empties this cycle.
  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_accept = out_tvalid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r <= PRESS_TICKS_RST;
      sign_ticks_r  <= SIGN_TICKS_RST;
      step_ticks_r  <= STEP_TICKS_RST;
    end else if (cfg_we) begin
      // Ignore writes beyond the register list.
      unique case (cfg_index)
        REG_PRESS_TICKS: press_ticks_r <= cfg_wdata;
        REG_SIGN_TICKS:  sign_ticks_r  <= cfg_wdata;
        REG_STEP_TICKS:  step_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    press_count_nxt = press_count_r;
    press_armed_nxt = press_armed_r;
    phase_nxt       = phase_r;
    phase_ticks_nxt = phase_ticks_r;
    rem_nxt         = rem_r;
    toggled         = 1'b0;
    ticks_inc       = phase_ticks_r + 16'd1;
    rem_dec         = (rem_r != '0) ? rem_r - 7'd1 : rem_r;

    // Press detector: release rearms, a long enough hold toggles once.
    if (!button_low) begin
      press_count_nxt = '0;
      press_armed_nxt = 1'b1;
    end else if (press_armed_r) begin
      if (press_count_r >= press_ticks_r) begin
        toggled         = 1'b1;
        press_armed_nxt = 1'b0;
      end else begin
        press_count_nxt = press_count_r + 16'd1;
      end
    end

    if (toggled) begin
      // Turning on enters the sign phase; turning off drops straight to idle.
      if (phase_r == PH_SIGN || phase_r == PH_RUN) begin
        phase_nxt = PH_IDLE;
        rem_nxt   = '0;
      end else begin
        phase_nxt = PH_SIGN;
      end
      phase_ticks_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_SIGN: begin
          phase_ticks_nxt = ticks_inc;
          if (ticks_inc >= sign_ticks_r) begin
            phase_nxt       = PH_RUN;
            phase_ticks_nxt = '0;
            rem_nxt         = load_count(adc_value);
          end
        end
        PH_RUN: begin
          phase_ticks_nxt = ticks_inc;
          if (ticks_inc >= step_ticks_r) begin
            phase_ticks_nxt = '0;
            rem_nxt         = rem_dec;
            if (rem_dec == '0) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
          // Idle, and the unused code, which acts as idle.
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Digits from the state after this tick.
    cnt  = (phase_nxt == PH_RUN) ? rem_nxt : '0;
    secs = tenths_to_sec(cnt);

    result_nxt.motor_on        = (phase_nxt == PH_RUN);
    result_nxt.display_enabled = (phase_nxt != PH_IDLE);
    result_nxt.show_on_sign    = (phase_nxt == PH_SIGN);
    // A 7-bit count stays below 600 tenths, so both minute digits are zero.
    result_nxt.minute_tens     = 4'd0;
    result_nxt.minute_ones     = 4'd0;
    result_nxt.second_tens     = (secs >= 4'd10) ? 3'd1 : 3'd0;
    result_nxt.second_ones     = (secs >= 4'd10) ? secs - 4'd10 : secs;
  end

  // Advance the state only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      press_count_r <= '0;
      press_armed_r <= 1'b1;
      phase_ticks_r <= '0;
      rem_r         <= '0;
    end else if (in_accept) begin
      phase_r       <= phase_nxt;
      press_count_r <= press_count_nxt;
      press_armed_r <= press_armed_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      rem_r         <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_accept) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, result_r};

`ifndef SYNTH
  // The run phase always holds a nonzero count.
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RUN) |-> (rem_r != '0))
    else $error("run phase with zero count");

  // Outside the run phase the count is cleared.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_RUN) |-> (rem_r == '0))
    else $error("count left over outside run phase");

  // A released button rearms the detector and clears its counter.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_tdata[0]) |=> (press_armed_r && press_count_r == '0))
    else $error("release did not rearm press detector");

  // A taken result with no new item empties the output register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_accept && !in_accept) |=> !out_tvalid_r)
    else $error("output register did not drain");
`endif

endmodule

// ----- verif/dispenser_countdown_controller_core_tb.sv -----
// Self-checking stream testbench for the dispenser countdown controller core.
`timescale 1ns / 100ps

module dispenser_countdown_controller_core_tb;
  import dcc_pkg::*;

  // Cycles without any handshake before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off below plus a short settle.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 4;
  // Register index past the end of the list; the block drops the write.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RES_W = $bits(result_t);

  // One directed stimulus row: either a register write or one tick item,
  // optionally carrying a hand-written expected display.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [TICK_W-1:0]    val;
    logic                 btn;
    logic [ADC_W-1:0]     adc;
    logic                 typed;
    result_t              want;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;    // [0] button_low, [10:1] adc_value
  logic                out_tvalid;
  logic                out_tready;
  // [0] motor_on, [1] display_enabled, [2] show_on_sign, [6:3] minute_tens,
  // [10:7] minute_ones, [13:11] second_tens, [17:14] second_ones
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]   cfg_wdata;

  dispenser_countdown_controller_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the controller: registers and state as the block should hold them.
  logic [TICK_W-1:0]  press_reg;
  logic [TICK_W-1:0]  sign_reg;
  logic [TICK_W-1:0]  step_reg;
  phase_t             ctl_phase;
  logic [TICK_W-1:0]  press_cnt;
  logic               press_armed;
  logic [TICK_W-1:0]  phase_cnt;
  logic [COUNT_W-1:0] remain;

  result_t     pending_displays[$];   // displays still owed by the block, oldest first
  plan_row_t   plan[$];
  int unsigned fail_cnt;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  result_t     mon_want;
  result_t     mon_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the shadow controller by one tick and return the display it shows.
  // Button first, then the phase timer; a toggle-on tick does not advance it.
  function automatic result_t advance_controller(input logic btn, input logic [ADC_W-1:0] adc);
    result_t     r;
    logic        flip;
    int unsigned cnt;
    int unsigned secs;
    flip = 1'b0;
    cnt = 0;
    if (!btn) begin
      press_cnt = '0;
      press_armed = 1'b1;
    end else if (press_armed) begin
      if (press_cnt >= press_reg) begin
        flip = 1'b1;
        press_armed = 1'b0;
      end else begin
        press_cnt = press_cnt + 1'b1;
      end
    end
    if (flip) begin
      // Turning off leaves from either active phase straight to idle.
      if (ctl_phase == PH_IDLE) begin
        ctl_phase = PH_SIGN;
      end else begin
        ctl_phase = PH_IDLE;
        remain = '0;
      end
      phase_cnt = '0;
    end else begin
      case (ctl_phase)
        PH_SIGN: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= sign_reg) begin
            ctl_phase = PH_RUN;
            phase_cnt = '0;
            // Sample of this tick picks 50, 60 or 70 tenths.
            remain = COUNT_W'(10 * (5 + (2 * int'(adc)) / 1020));
          end
        end
        PH_RUN: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= step_reg) begin
            phase_cnt = '0;
            if (remain != '0) remain = remain - 1'b1;
            if (remain == '0) ctl_phase = PH_IDLE;
          end
        end
        default: begin
          ctl_phase = PH_IDLE;
        end
      endcase
    end
    if (ctl_phase == PH_RUN) cnt = 32'(remain);
    secs = cnt / 10;
    r.motor_on        = (ctl_phase == PH_RUN);
    r.display_enabled = (ctl_phase != PH_IDLE);
    r.show_on_sign    = (ctl_phase == PH_SIGN);
    r.minute_tens     = 4'(cnt / 6000);
    r.minute_ones     = 4'((cnt / 600) % 10);
    r.second_tens     = 3'((secs % 60) / 10);
    r.second_ones     = 4'((secs % 60) % 10);
    return r;
  endfunction

  // Hand-written display: digits other than the seconds ones are zero here.
  function automatic result_t view(input logic motor, input logic lit, input logic sign,
                                   input logic [3:0] sec1);
    result_t r;
    r = '0;
    r.motor_on = motor;
    r.display_enabled = lit;
    r.show_on_sign = sign;
    r.second_ones = sec1;
    return r;
  endfunction

  function automatic logic [ADC_W-1:0] pick_adc();
    logic [ADC_W-1:0] a;
    // Lean on the load thresholds and the ends of the range.
    case ($urandom_range(7))
      0: a = '0;
      1: a = 10'd509;
      2: a = 10'd510;
      3: a = 10'd1019;
      4: a = 10'd1020;
      5: a = 10'd1023;
      default: a = ADC_W'($urandom_range(1023));
    endcase
    return a;
  endfunction

  task automatic add_tick(input logic btn, input logic [ADC_W-1:0] adc, input logic typed,
                          input result_t want);
    plan_row_t row;
    row = '0;
    row.btn = btn;
    row.adc = adc;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    plan.push_back(row);
  endtask

  // Offer one tick item, idling first as the sender setting asks. Called and
  // returns at a falling edge; tvalid stays high unless an idle cycle is taken.
  task automatic send_tick(input logic btn, input logic [ADC_W-1:0] adc, input logic typed,
                           input result_t want);
    result_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {{(IN_W - ADC_W - 1){1'b0}}, adc, btn};
    do @(posedge clk); while (!in_tready);
    guess = advance_controller(btn, adc);
    pending_displays.push_back(typed ? want : guess);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid and wait until every owed display has come back.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending_displays.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_PRESS_TICKS: press_reg = val;
      REG_SIGN_TICKS:  sign_reg = val;
      REG_STEP_TICKS:  step_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random ticks shaped as button activity: mostly clean presses long enough
  // to toggle, long releases that let a countdown run out, bounces and noise.
  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned seg;
    int unsigned len;
    int unsigned k;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      seg = $urandom_range(99);
      if (seg < 60) begin
        if (press_reg < 64) len = press_reg + 1 + $urandom_range(3);
        else len = $urandom_range(1, 200);
        for (k = 0; k < len; k++) send_tick(1'b1, pick_adc(), 1'b0, '0);
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) send_tick(1'b0, pick_adc(), 1'b0, '0);
      end else if (seg < 80) begin
        len = $urandom_range(40, 250);
        for (k = 0; k < len; k++) send_tick(1'b0, pick_adc(), 1'b0, '0);
      end else if (seg < 90) begin
        len = (press_reg < 64) ? $urandom_range(1, press_reg + 1) : $urandom_range(1, 200);
        for (k = 0; k < len; k++) send_tick(1'b1, pick_adc(), 1'b0, '0);
        send_tick(1'b0, pick_adc(), 1'b0, '0);
      end else begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) send_tick(1'(($urandom_range(1))), pick_adc(), 1'b0, '0);
      end
    end
  endtask

  // One random phase: bring the controller back to idle, reprogram it, set
  // the idling mix and run.
  task automatic run_phase(input logic [TICK_W-1:0] press, input logic [TICK_W-1:0] sign,
                           input logic [TICK_W-1:0] step, input int unsigned idle_pct,
                           input int unsigned stall, input int unsigned n,
                           input logic squeeze);
    int unsigned k;
    // Press until the shadow says idle so no register changes under a live timer.
    while (ctl_phase != PH_IDLE) begin
      send_tick(1'b0, pick_adc(), 1'b0, '0);
      for (k = 0; k <= press_reg && ctl_phase != PH_IDLE; k++)
        send_tick(1'b1, pick_adc(), 1'b0, '0);
    end
    settle();
    write_reg(REG_PRESS_TICKS, press);
    write_reg(REG_SIGN_TICKS, sign);
    write_reg(REG_STEP_TICKS, step);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    // Hold the receiver off while the sender keeps offering, so the input stalls.
    if (squeeze) hold_req = HOLD_OFF_CYCLES;
    run_random(n);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare every accepted result with the oldest owed display.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_displays.size() == 0) begin
        $error("result item with no display owed: %h", out_tdata);
        fail_cnt++;
      end else begin
        mon_want = pending_displays.pop_front();
        mon_seen = result_t'(out_tdata[RES_W-1:0]);
        check_field("motor_on", mon_want.motor_on, mon_seen.motor_on);
        check_field("display_enabled", mon_want.display_enabled, mon_seen.display_enabled);
        check_field("show_on_sign", mon_want.show_on_sign, mon_seen.show_on_sign);
        check_field("minute_tens", mon_want.minute_tens, mon_seen.minute_tens);
        check_field("minute_ones", mon_want.minute_ones, mon_seen.minute_ones);
        check_field("second_tens", mon_want.second_tens, mon_seen.second_tens);
        check_field("second_ones", mon_want.second_ones, mon_seen.second_ones);
        check_field("tdata padding", 0, out_tdata[OUT_W-1:RES_W]);
      end
    end
  end

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fail_cnt = 0;
    items_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    press_reg = PRESS_TICKS_RST;
    sign_reg = SIGN_TICKS_RST;
    step_reg = STEP_TICKS_RST;
    ctl_phase = PH_IDLE;
    press_cnt = '0;
    press_armed = 1'b1;
    phase_cnt = '0;
    remain = '0;

    // Directed plan. Reset values first: a short press does nothing.
    add_tick(1'b0, 10'd0, 1'b1, view(0, 0, 0, 0));
    add_tick(1'b1, 10'd1023, 1'b1, view(0, 0, 0, 0));
    add_tick(1'b1, 10'd0, 1'b1, view(0, 0, 0, 0));
    // Zero press threshold toggles on the first low tick; zero step acts like one.
    add_cfg(REG_PRESS_TICKS, 16'd0);
    add_cfg(REG_SIGN_TICKS, 16'd3);
    add_cfg(REG_STEP_TICKS, 16'd0);
    add_cfg(REG_UNUSED, 16'hFFFF);
    add_tick(1'b0, 10'd0, 1'b1, view(0, 0, 0, 0));
    add_tick(1'b1, 10'd0, 1'b1, view(0, 1, 1, 0));
    add_tick(1'b0, 10'd0, 1'b0, '0);
    // Press during the sign phase: straight back to idle.
    add_tick(1'b1, 10'd0, 1'b1, view(0, 0, 0, 0));
    add_tick(1'b0, 10'd0, 1'b0, '0);
    add_tick(1'b1, 10'd509, 1'b1, view(0, 1, 1, 0));
    add_tick(1'b1, 10'd509, 1'b0, '0);
    add_tick(1'b1, 10'd509, 1'b0, '0);
    // Sign time over: load 50 tenths from the lower band.
    add_tick(1'b1, 10'd509, 1'b1, view(1, 1, 0, 5));
    add_tick(1'b0, 10'd0, 1'b0, '0);
    // Press during the run: motor and display off.
    add_tick(1'b1, 10'd0, 1'b1, view(0, 0, 0, 0));
    add_tick(1'b0, 10'd1023, 1'b0, '0);
    add_tick(1'b1, 10'd1023, 1'b1, view(0, 1, 1, 0));
    add_tick(1'b1, 10'd1023, 1'b0, '0);
    add_tick(1'b1, 10'd1023, 1'b0, '0);
    // Top of the sample range loads 70 tenths.
    add_tick(1'b1, 10'd1023, 1'b1, view(1, 1, 0, 7));
    add_tick(1'b0, 10'd510, 1'b0, '0);
    add_tick(1'b1, 10'd510, 1'b1, view(0, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_tick(plan[i].btn, plan[i].adc, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: small timings so runs finish, then the register extremes.
    // Each phase overshoots its count by the tail of its last segment.
    run_phase(16'd2, 16'd4, 16'd1, 0, 0, 200, 1'b0);
    run_phase(16'd1, 16'd1, 16'd2, 48, 0, 200, 1'b0);
    run_phase(16'd0, 16'd0, 16'd0, 0, 48, 170, 1'b1);
    run_phase(16'd3, 16'd7, 16'd3, 16, 16, 200, 1'b0);
    run_phase(16'hFFFF, 16'd1, 16'd1, 0, 0, 80, 1'b0);
    run_phase(16'd1, 16'hFFFF, 16'd1, 48, 48, 80, 1'b0);
    run_phase(16'd1, 16'd1, 16'hFFFF, 0, 0, 80, 1'b0);

    // Drain, then give a stray late result a chance to show up.
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dcc_pkg.sv
sv/dispenser_countdown_controller_core.sv
verif/dispenser_countdown_controller_core_tb.sv
